### rtl/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned EV_W          = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam logic [EV_W-1:0] EV_DATA = 3'd0;
  localparam logic [EV_W-1:0] EV_OK   = 3'd1;
  localparam logic [EV_W-1:0] EV_BCC  = 3'd2;
  localparam logic [EV_W-1:0] EV_LEN  = 3'd3;
  localparam logic [EV_W-1:0] EV_ESC  = 3'd4;
  localparam logic [EV_W-1:0] EV_LONG = 3'd5;
  localparam logic [EV_W-1:0] EV_ACK  = 3'd6;
  localparam logic [EV_W-1:0] EV_NAK  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NAK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_OFF = 3'd7;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] escape_mask;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic [3:0] header_length;
    logic [3:0] length_field_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_code:          8'h02,
    end_code:            8'h03,
    escape_code:         8'h10,
    escape_mask:         8'h40,
    ack_code:            8'h06,
    nak_code:            8'h15,
    header_length:       4'd4,
    length_field_offset: 4'd3
  };

  typedef struct packed {
    logic              vld;
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] idx;
  } res_t;

endpackage

`default_nettype wire

### rtl/dfr_cfg_regs.sv
`default_nettype none

module dfr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dfr_pkg::BYTE_W-1:0]     cfg_wdata,
  output dfr_pkg::cfg_t                       cfg
);

  dfr_pkg::cfg_t cfg_r;
  dfr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::REG_START:   cfg_nxt.start_code          = cfg_wdata;
        dfr_pkg::REG_END:     cfg_nxt.end_code            = cfg_wdata;
        dfr_pkg::REG_ESCAPE:  cfg_nxt.escape_code         = cfg_wdata;
        dfr_pkg::REG_MASK:    cfg_nxt.escape_mask         = cfg_wdata;
        dfr_pkg::REG_ACK:     cfg_nxt.ack_code            = cfg_wdata;
        dfr_pkg::REG_NAK:     cfg_nxt.nak_code            = cfg_wdata;
        dfr_pkg::REG_HDR_LEN: cfg_nxt.header_length       = cfg_wdata[3:0];
        dfr_pkg::REG_LEN_OFF: cfg_nxt.length_field_offset = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dfr_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/dfr_parser.sv
`default_nettype none

module dfr_parser #(
  parameter int unsigned MAX_FRAME = dfr_pkg::MAX_FRAME_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dfr_pkg::cfg_t               cfg,
  input  wire logic                        fire,
  input  wire logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
  output dfr_pkg::res_t                    res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAME - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_BCC  = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic             do_store;
  logic [7:0]       store_b;
  logic             esc_ok;
  logic [7:0]       body_len;

  assign esc_ok = (rx_byte == (cfg.start_code ^ cfg.escape_mask)) ||
                  (rx_byte == (cfg.end_code ^ cfg.escape_mask)) ||
                  (rx_byte == (cfg.escape_code ^ cfg.escape_mask));
  assign body_len = 8'(cnt_r) - 8'(cfg.header_length);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    dlen_nxt  = dlen_r;
    res       = '0;
    do_store  = 1'b0;
    store_b   = rx_byte;
    if (phase_r == PH_BCC) begin
      phase_nxt = PH_IDLE;
      res.vld   = 1'b1;
      if (acc_r != rx_byte) begin
        cnt_nxt = '0;
        res.ev  = dfr_pkg::EV_BCC;
      end else if (dlen_r != body_len) begin
        cnt_nxt = '0;
        res.ev  = dfr_pkg::EV_LEN;
      end else begin
        res.ev  = dfr_pkg::EV_OK;
      end
    end else if (rx_byte == cfg.start_code) begin
      phase_nxt = PH_DATA;
      acc_nxt   = rx_byte;
      cnt_nxt   = '0;
      dlen_nxt  = '0;
    end else if (rx_byte == cfg.end_code) begin
      phase_nxt = PH_BCC;
      acc_nxt   = acc_r ^ rx_byte;
    end else if (rx_byte == cfg.escape_code) begin
      if (phase_r == PH_DATA) begin
        phase_nxt = PH_ESC;
        acc_nxt   = acc_r ^ rx_byte;
      end
    end else if (phase_r == PH_DATA) begin
      acc_nxt  = acc_r ^ rx_byte;
      do_store = 1'b1;
    end else if (phase_r == PH_ESC) begin
      if (esc_ok) begin
        phase_nxt = PH_DATA;
        acc_nxt   = acc_r ^ rx_byte;
        do_store  = 1'b1;
        store_b   = rx_byte ^ cfg.escape_mask;
      end else begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
        res.vld   = 1'b1;
        res.ev    = dfr_pkg::EV_ESC;
      end
    end else if (rx_byte == cfg.ack_code) begin
      res.vld = 1'b1;
      res.ev  = dfr_pkg::EV_ACK;
    end else if (rx_byte == cfg.nak_code) begin
      res.vld = 1'b1;
      res.ev  = dfr_pkg::EV_NAK;
    end

    if (do_store) begin
      res.vld = 1'b1;
      if (cnt_r == CNT_LAST) begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
        res.ev    = dfr_pkg::EV_LONG;
      end else begin
        if (9'(cnt_r) == 9'(cfg.length_field_offset)) begin
          dlen_nxt = store_b;
        end
        cnt_nxt  = cnt_r + CNT_W'(1);
        res.ev   = dfr_pkg::EV_DATA;
        res.data = store_b;
        res.idx  = 8'(cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      dlen_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      dlen_r  <= dlen_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/dfr_out_reg.sv
`default_nettype none

module dfr_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire dfr_pkg::res_t               res,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [dfr_pkg::EV_W-1:0]         out_event_res,
  output logic [dfr_pkg::BYTE_W-1:0]       out_payload_byte,
  output logic [dfr_pkg::BYTE_W-1:0]       out_payload_index
);

  logic                        vld_r, vld_nxt;
  logic [dfr_pkg::EV_W-1:0]    ev_r;
  logic [dfr_pkg::BYTE_W-1:0]  data_r;
  logic [dfr_pkg::BYTE_W-1:0]  idx_r;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= res.ev;
      data_r <= res.data;
      idx_r  <= res.idx;
    end
  end

  assign out_valid         = vld_r;
  assign out_event_res     = ev_r;
  assign out_payload_byte  = data_r;
  assign out_payload_index = idx_r;

endmodule

`default_nettype wire

### rtl/dle_frame_receiver_xor_bcc.sv
// DLE frame receiver with XOR block check.
// Input channel: one received serial byte per transaction on in_rx_byte,
// handshaked by in_valid and in_stall. Output channel: zero or one event per
// input byte on out_event_res, out_payload_byte and out_payload_index, with
// out_valid and out_stall. Data events carry the unescaped byte and its
// index in the frame; all other events carry zeros in those fields.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata, and should only be changed while no transaction is in flight.
// An accepted byte is registered in the input register and decoded once the
// output register is empty or being drained; its event then loads there.
// One byte is taken every cycle while in_stall is low.
// When the receiver holds out_stall, the pending event stays put and one
// more byte may wait in the input register; in_stall rises only once both
// are full. Reset clears the frame state to idle, loads the default codes
// and empties both registers.
`default_nettype none

module dle_frame_receiver_xor_bcc #(
  parameter int unsigned MAX_FRAME = dfr_pkg::MAX_FRAME_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dfr_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [dfr_pkg::EV_W-1:0]            out_event_res,
  output logic [dfr_pkg::BYTE_W-1:0]          out_payload_byte,
  output logic [dfr_pkg::BYTE_W-1:0]          out_payload_index,
  input  wire logic                           cfg_we,
  input  wire logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dfr_pkg::BYTE_W-1:0]     cfg_wdata
);

  dfr_pkg::cfg_t               cfg;
  dfr_pkg::res_t               res;
  logic                        s1_vld_r, s1_vld_nxt;
  logic [dfr_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        s1_fire;
  logic                        in_accept;

  assign s1_fire   = s1_vld_r && (!out_valid || !out_stall);
  assign in_stall  = s1_vld_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  dfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (s1_fire),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  dfr_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (s1_fire && res.vld),
    .res               (res),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_event_res     (out_event_res),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index)
  );

endmodule

`default_nettype wire

### rtl/dfr_checker.sv
`default_nettype none

module dfr_checker #(
  parameter int unsigned MAX_FRAME = dfr_pkg::MAX_FRAME_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [dfr_pkg::EV_W-1:0]    out_event_res,
  input wire logic [dfr_pkg::BYTE_W-1:0]  out_payload_byte,
  input wire logic [dfr_pkg::BYTE_W-1:0]  out_payload_index
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side is free");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res != dfr_pkg::EV_DATA)) |->
      (out_payload_byte == '0 && out_payload_index == '0))
    else $error("control event carries a non-zero payload");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == dfr_pkg::EV_DATA)) |->
      (int'(out_payload_index) <= int'(MAX_FRAME) - 2))
    else $error("payload index beyond the frame limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_event_res) && $stable(out_payload_byte) &&
       $stable(out_payload_index)))
    else $error("stalled output transaction changed");

endmodule

bind dle_frame_receiver_xor_bcc dfr_checker #(
  .MAX_FRAME (MAX_FRAME)
) u_dfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_event_res     (out_event_res),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAME_LIMIT = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_ESC, RX_BCC} rx_state_e;

  typedef struct packed {
    logic [dfr_pkg::EV_W-1:0]   code;
    logic [dfr_pkg::BYTE_W-1:0] data;
    logic [dfr_pkg::BYTE_W-1:0] index;
  } rx_event_t;

  typedef logic [7:0] octet_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dfr_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dfr_pkg::EV_W-1:0] out_event_res;
  logic [dfr_pkg::BYTE_W-1:0] out_payload_byte;
  logic [dfr_pkg::BYTE_W-1:0] out_payload_index;
  logic cfg_we = 1'b0;
  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dfr_pkg::BYTE_W-1:0] cfg_wdata = '0;

  dfr_pkg::cfg_t model_cfg = dfr_pkg::CFG_RESET;
  rx_state_e rx_state = RX_IDLE;
  logic [7:0] check_acc = '0;
  logic [8:0] frame_count = '0;
  logic [7:0] declared_len = '0;

  rx_event_t awaited_events[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  dle_frame_receiver_xor_bcc #(.MAX_FRAME(FRAME_LIMIT)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit store_payload(input logic [7:0] value, output rx_event_t ev);
    ev = '0;
    if (int'(frame_count) + 1 >= FRAME_LIMIT) begin
      rx_state = RX_IDLE;
      frame_count = '0;
      ev.code = dfr_pkg::EV_LONG;
    end else begin
      if (frame_count == {5'b0, model_cfg.length_field_offset}) declared_len = value;
      ev.code = dfr_pkg::EV_DATA;
      ev.data = value;
      ev.index = frame_count[7:0];
      frame_count = frame_count + 9'd1;
    end
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] value, output rx_event_t ev);
    logic [7:0] body_len;
    logic [7:0] mask;
    mask = model_cfg.escape_mask;
    ev = '0;
    if (rx_state == RX_BCC) begin
      rx_state = RX_IDLE;
      body_len = frame_count[7:0] - {4'h0, model_cfg.header_length};
      if (check_acc != value) begin
        frame_count = '0;
        ev.code = dfr_pkg::EV_BCC;
      end else if (declared_len != body_len) begin
        frame_count = '0;
        ev.code = dfr_pkg::EV_LEN;
      end else begin
        ev.code = dfr_pkg::EV_OK;
      end
      return 1'b1;
    end
    if (value == model_cfg.start_code) begin
      rx_state = RX_DATA;
      check_acc = value;
      frame_count = '0;
      declared_len = '0;
      return 1'b0;
    end
    if (value == model_cfg.end_code) begin
      rx_state = RX_BCC;
      check_acc ^= value;
      return 1'b0;
    end
    if (value == model_cfg.escape_code) begin
      if (rx_state == RX_DATA) begin
        rx_state = RX_ESC;
        check_acc ^= value;
      end
      return 1'b0;
    end
    if (rx_state == RX_DATA) begin
      check_acc ^= value;
      return store_payload(value, ev);
    end
    if (rx_state == RX_ESC) begin
      if (value == (model_cfg.start_code ^ mask) || value == (model_cfg.end_code ^ mask) ||
          value == (model_cfg.escape_code ^ mask)) begin
        rx_state = RX_DATA;
        check_acc ^= value;
        return store_payload(value ^ mask, ev);
      end
      rx_state = RX_IDLE;
      frame_count = '0;
      ev.code = dfr_pkg::EV_ESC;
      return 1'b1;
    end
    if (value == model_cfg.ack_code) begin
      ev.code = dfr_pkg::EV_ACK;
      return 1'b1;
    end
    if (value == model_cfg.nak_code) begin
      ev.code = dfr_pkg::EV_NAK;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int gap;
    rx_event_t ev;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= value;
    do @(posedge clk); while (in_stall);
    if (deframe_byte(value, ev)) awaited_events.push_back(ev);
  endtask

  task automatic send_frame(input octet_q_t body, input logic [7:0] bcc_flip);
    logic [7:0] acc;
    logic [7:0] coded;
    acc = model_cfg.start_code;
    send_byte(model_cfg.start_code);
    foreach (body[i]) begin
      if (body[i] == model_cfg.start_code || body[i] == model_cfg.end_code ||
          body[i] == model_cfg.escape_code) begin
        coded = body[i] ^ model_cfg.escape_mask;
        send_byte(model_cfg.escape_code);
        send_byte(coded);
        acc ^= model_cfg.escape_code ^ coded;
      end else begin
        send_byte(body[i]);
        acc ^= body[i];
      end
    end
    acc ^= model_cfg.end_code;
    send_byte(model_cfg.end_code);
    send_byte(acc ^ bcc_flip);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [dfr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      dfr_pkg::REG_START:   model_cfg.start_code = value;
      dfr_pkg::REG_END:     model_cfg.end_code = value;
      dfr_pkg::REG_ESCAPE:  model_cfg.escape_code = value;
      dfr_pkg::REG_MASK:    model_cfg.escape_mask = value;
      dfr_pkg::REG_ACK:     model_cfg.ack_code = value;
      dfr_pkg::REG_NAK:     model_cfg.nak_code = value;
      dfr_pkg::REG_HDR_LEN: model_cfg.header_length = value[3:0];
      dfr_pkg::REG_LEN_OFF: model_cfg.length_field_offset = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input dfr_pkg::cfg_t c);
    wait_idle();
    write_register(dfr_pkg::REG_START, c.start_code);
    write_register(dfr_pkg::REG_END, c.end_code);
    write_register(dfr_pkg::REG_ESCAPE, c.escape_code);
    write_register(dfr_pkg::REG_MASK, c.escape_mask);
    write_register(dfr_pkg::REG_ACK, c.ack_code);
    write_register(dfr_pkg::REG_NAK, c.nak_code);
    write_register(dfr_pkg::REG_HDR_LEN, {4'($urandom), c.header_length});
    write_register(dfr_pkg::REG_LEN_OFF, {4'($urandom), c.length_field_offset});
    cfg_we <= 1'b0;
  endtask

  function automatic dfr_pkg::cfg_t random_config();
    dfr_pkg::cfg_t c;
    logic [7:0] m;
    do begin
      c.start_code = 8'($urandom);
      c.end_code = 8'($urandom);
      c.escape_code = 8'($urandom);
      c.escape_mask = 8'($urandom);
      m = c.escape_mask;
    end while (c.start_code == c.end_code || c.start_code == c.escape_code ||
               c.end_code == c.escape_code || m == 8'h00 ||
               (c.start_code ^ m) == c.end_code || (c.start_code ^ m) == c.escape_code ||
               (c.end_code ^ m) == c.escape_code);
    c.ack_code = 8'($urandom);
    c.nak_code = 8'($urandom);
    c.header_length = 4'($urandom_range(0, 15));
    c.length_field_offset = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic logic [7:0] payload_value();
    case ($urandom_range(0, 11))
      0: return model_cfg.start_code;
      1: return model_cfg.end_code;
      2: return model_cfg.escape_code;
      3: return model_cfg.ack_code;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random_traffic(input int byte_budget);
    octet_q_t body;
    int len;
    int kind;
    byte_budget = byte_budget + awaited_events.size();
    for (int sent = 0; sent < byte_budget; ) begin
      kind = $urandom_range(0, 99);
      body.delete();
      if (kind < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) body.push_back(payload_value());
        if (model_cfg.length_field_offset < len) begin
          if ($urandom_range(0, 9) == 0) body[model_cfg.length_field_offset] = 8'($urandom);
          else body[model_cfg.length_field_offset] = 8'(len - model_cfg.header_length);
        end
        send_frame(body, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        sent += len + 3;
      end else if (kind < 80) begin
        case ($urandom_range(0, 4))
          0: send_byte(model_cfg.ack_code);
          1: send_byte(model_cfg.nak_code);
          2: send_byte(model_cfg.end_code);
          3: send_byte(model_cfg.escape_code);
          default: send_byte(8'($urandom));
        endcase
        sent += 1;
      end else if (kind < 90) begin
        len = $urandom_range(0, 5);
        send_byte(model_cfg.start_code);
        for (int i = 0; i < len; i++) send_byte(8'($urandom));
        send_byte(model_cfg.escape_code);
        send_byte(($urandom_range(0, 1) == 0) ? model_cfg.start_code : 8'($urandom));
        sent += len + 3;
      end else begin
        len = $urandom_range(1, 6);
        send_byte(model_cfg.start_code);
        for (int i = 0; i < len; i++) send_byte(payload_value());
        sent += len + 1;
      end
    end
  endtask

  task automatic test_idle_codes();
    send_byte(8'h06);
    send_byte(8'h15);
    send_byte(8'h10);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_frame_outcomes();
    send_frame('{8'h03, 8'h02, 8'h10, 8'h00}, 8'h00);
    send_frame('{8'h55}, 8'h01);
    send_frame('{8'h11, 8'h22, 8'h33, 8'h05, 8'h44}, 8'h00);
  endtask

  task automatic test_broken_sequences();
    send_byte(8'h02);
    send_byte(8'h10);
    send_byte(8'h77);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(8'h10);
    send_byte(8'h02);
    send_byte(8'hBB);
    send_byte(8'h02);
    send_byte(8'hCC);
    send_byte(8'h03);
    send_byte(8'hCD);
    send_byte(8'h03);
    send_byte(8'h00);
  endtask

  task automatic test_frame_overflow();
    octet_q_t body;
    for (int i = 0; i < FRAME_LIMIT - 1; i++) body.push_back(8'($urandom));
    body[model_cfg.length_field_offset] = 8'(FRAME_LIMIT - 1 - model_cfg.header_length);
    send_frame(body, 8'h00);
    for (int i = 0; i < 5; i++) body.push_back(8'($urandom));
    send_frame(body, 8'h00);
  endtask

  task automatic test_config_sweep();
    dfr_pkg::cfg_t c;
    c = '0;
    apply_config(c);
    run_random_traffic(30);
    c = '1;
    apply_config(c);
    run_random_traffic(30);
    repeat (3) begin
      apply_config(random_config());
      run_random_traffic(30);
    end
    apply_config(dfr_pkg::CFG_RESET);
    run_random_traffic(25);
  endtask

  task automatic report_mismatch(input string what, input rx_event_t want, input rx_event_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch (%s) cycle %0d: exp %0d/%02h/%0d, got %0d/%02h/%0d",
               what, cycle_count, want.code, want.data, want.index, got.code, got.data,
               got.index);
  endtask

  always @(posedge clk) begin
    rx_event_t got;
    rx_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{code: out_event_res, data: out_payload_byte, index: out_payload_index};
      if (awaited_events.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        want = awaited_events.pop_front();
        if (got.code != want.code) report_mismatch("event", want, got);
        else if (got.data != want.data) report_mismatch("payload byte", want, got);
        else if (got.index != want.index) report_mismatch("payload index", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run <= $urandom_range(20, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_run % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_codes();
    test_frame_outcomes();
    test_broken_sequences();
    test_frame_overflow();
    test_config_sweep();
    wait_idle();
    if (mismatch_count == 0 && awaited_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dfr_pkg.sv
rtl/dfr_cfg_regs.sv
rtl/dfr_parser.sv
rtl/dfr_out_reg.sv
rtl/dle_frame_receiver_xor_bcc.sv
rtl/dfr_checker.sv
test/testbench.sv
